// ===== src/pcrc16_pkg.sv =====
// Package for the parametric CRC-16 engine: widths, reset values, register
// indexes and the bit-reversal helpers. No dependencies.
package pcrc16_pkg;

  localparam int unsigned MaxCrcWidth = 16;
  localparam int unsigned SymbolBits  = 8;
  localparam int unsigned CfgIndexW   = 3;
  localparam int unsigned CfgWidthW   = 5;
  localparam int unsigned ShiftW      = 4;

  typedef logic [MaxCrcWidth-1:0] crc_t;
  typedef logic [SymbolBits-1:0]  sym_t;
  typedef logic [CfgWidthW-1:0]   width_t;
  typedef logic [ShiftW-1:0]      shift_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_CRC_WIDTH      = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_START_VALUE    = 3'd2,
    REG_OUTPUT_MASK    = 3'd3,
    REG_REFLECT_INPUT  = 3'd4,
    REG_REFLECT_OUTPUT = 3'd5
  } cfg_reg_e;

  localparam width_t RstCrcWidth     = width_t'(16);
  localparam crc_t   RstPolynomial   = crc_t'(16'h8005);
  localparam crc_t   RstStartValue   = crc_t'(16'hFFFF);
  localparam crc_t   RstOutputMask   = crc_t'(16'h0000);
  localparam logic   RstReflectIn    = 1'b1;
  localparam logic   RstReflectOut   = 1'b1;

  // Full-width bit reversal.
  function automatic crc_t rev_full(input crc_t v);
    crc_t r;
    for (int i = 0; i < MaxCrcWidth; i++) begin
      r[i] = v[MaxCrcWidth-1-i];
    end
    return r;
  endfunction

  // Reversal over the low (MaxCrcWidth - sh) bits; v must be zero above them.
  function automatic crc_t rev_width(input crc_t v, input shift_t sh);
    return rev_full(v) >> sh;
  endfunction

endpackage

// ===== src/parametric_crc16_engine_top.sv =====
// Top level of the parametric CRC-16 engine (byte-serial, 8 to 16 bit CRC).
// Depends on pcrc16_pkg.
//
// The engine takes one message byte per request and accepts a new byte in
// every clock cycle. A byte is first captured in an input register; from
// there the eight polynomial steps of the byte update are applied
// in one pass of XOR logic to the CRC register, so the running remainder is
// ready for the next byte without a gap. A request with last_byte set also
// loads the finished checksum into the output register, where it waits for
// the downstream side while new bytes keep flowing in behind it; the input
// side stalls only when a second final byte meets a result that has not yet
// been taken. A final checksum passes the input register and the output
// register to the result port. The CRC width, polynomial, start value,
// output mask and the two reflection options are set through a write port
// and must only be changed while no request is held inside the engine; a
// message may stay open across a change, and its remaining bytes use the
// new settings. Width settings below 8 act as 8 and above 16 act as 16; only
// the low width bits of the polynomial, start value and mask take effect.
// The default setting is the common MODBUS checksum.
module parametric_crc16_engine_top
  import pcrc16_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [MaxCrcWidth-1:0] cfg_data_i,
  // byte requests
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SymbolBits-1:0] data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  // checksum results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MaxCrcWidth-1:0] crc_value_o
);

  // Configuration registers.
  width_t crc_width_q;
  crc_t   polynomial_q;
  crc_t   start_value_q;
  crc_t   output_mask_q;
  logic   reflect_in_q;
  logic   reflect_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_width_q   <= RstCrcWidth;
      polynomial_q  <= RstPolynomial;
      start_value_q <= RstStartValue;
      output_mask_q <= RstOutputMask;
      reflect_in_q  <= RstReflectIn;
      reflect_out_q <= RstReflectOut;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CRC_WIDTH:      crc_width_q   <= cfg_data_i[CfgWidthW-1:0];
        REG_POLYNOMIAL:     polynomial_q  <= cfg_data_i;
        REG_START_VALUE:    start_value_q <= cfg_data_i;
        REG_OUTPUT_MASK:    output_mask_q <= cfg_data_i;
        REG_REFLECT_INPUT:  reflect_in_q  <= cfg_data_i[0];
        REG_REFLECT_OUTPUT: reflect_out_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective width as a right-shift amount from the full 16 bits, and the
  // matching mask. The reflected polynomial is fixed per configuration.
  width_t eff_width;
  shift_t shift_amt;
  crc_t   width_mask;
  crc_t   poly_m;
  crc_t   rpoly;

  always_comb begin
    if (crc_width_q < width_t'(SymbolBits)) begin
      eff_width = width_t'(SymbolBits);
    end else if (crc_width_q > width_t'(MaxCrcWidth)) begin
      eff_width = width_t'(MaxCrcWidth);
    end else begin
      eff_width = crc_width_q;
    end
    shift_amt  = shift_t'(width_t'(MaxCrcWidth) - eff_width);
    width_mask = {MaxCrcWidth{1'b1}} >> shift_amt;
    poly_m     = polynomial_q & width_mask;
    rpoly      = rev_width(poly_m, shift_amt);
  end

  // Input register stage.
  logic s1_valid_q;
  sym_t s1_byte_q;
  logic s1_first_q;
  logic s1_last_q;
  logic s1_take;
  logic out_load_ok;
  logic out_valid_q;
  crc_t out_crc_q;

  assign out_load_ok = !out_valid_q || out_ready_i;
  // A byte that does not end a message never waits on the result side.
  assign s1_take    = s1_valid_q && (!s1_last_q || out_load_ok);
  assign in_ready_o = !s1_valid_q || s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
      s1_last_q  <= last_byte_i;
    end
  end

  // Byte update: eight polynomial steps, LSB-first on the native register
  // when reflected, MSB-first on a left-aligned copy otherwise.
  crc_t crc_q;
  crc_t crc_d;
  crc_t reg_start;
  crc_t reg_refl;
  crc_t reg_norm;
  crc_t final_crc;

  always_comb begin
    if (s1_first_q) begin
      reg_start = start_value_q & width_mask;
      if (reflect_in_q) begin
        reg_start = rev_width(reg_start, shift_amt);
      end
    end else begin
      reg_start = crc_q & width_mask;
    end

    reg_refl = reg_start ^ crc_t'(s1_byte_q);
    for (int i = 0; i < SymbolBits; i++) begin
      if (reg_refl[0]) begin
        reg_refl = (reg_refl >> 1) ^ rpoly;
      end else begin
        reg_refl = reg_refl >> 1;
      end
    end

    reg_norm = (reg_start << shift_amt) ^ (crc_t'(s1_byte_q) << (MaxCrcWidth - SymbolBits));
    for (int i = 0; i < SymbolBits; i++) begin
      if (reg_norm[MaxCrcWidth-1]) begin
        reg_norm = (reg_norm << 1) ^ (poly_m << shift_amt);
      end else begin
        reg_norm = reg_norm << 1;
      end
    end
    reg_norm = reg_norm >> shift_amt;

    crc_d = (reflect_in_q ? reg_refl : reg_norm) & width_mask;

    // Reflecting back for input and again for output cancel each other.
    if (reflect_in_q ^ reflect_out_q) begin
      final_crc = rev_width(crc_d, shift_amt);
    end else begin
      final_crc = crc_d;
    end
    final_crc = (final_crc ^ output_mask_q) & width_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else if (s1_take) begin
      crc_q <= crc_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_q <= s1_take && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && s1_last_q) begin
      out_crc_q <= final_crc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  // A new result only appears after a final byte left the input register.
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_take && s1_last_q))
    else $error("result appeared without a final byte");

  // The running remainder only moves when a byte is processed.
  a_crc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_take |=> $stable(crc_q))
    else $error("CRC register changed without a byte");

  // A final byte facing a stalled result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while final byte is stalled");

  // Bytes that end no message always pass through the update stage.
  a_mid_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last_q) |-> s1_take)
    else $error("mid-message byte stalled");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for parametric_crc16_engine_top: byte requests with random
// messages, checksums predicted in the testbench and compared on the result port.
// Depends on pcrc16_pkg and the engine top level.
module testbench;
  import pcrc16_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned RandPhases   = 12;
  localparam int unsigned PhaseBytes   = 82;
  localparam int unsigned QuietPhases  = 2;

  // One byte request as it is handed to the engine.
  typedef struct packed {
    sym_t data;
    logic first;
    logic last;
  } byte_req_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [CfgIndexW-1:0]   cfg_index_i  = '0;
  logic [MaxCrcWidth-1:0] cfg_data_i   = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [SymbolBits-1:0]  data_byte_i  = '0;
  logic                   first_byte_i = 1'b0;
  logic                   last_byte_i  = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [MaxCrcWidth-1:0] crc_value_o;

  parametric_crc16_engine_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .crc_value_o  (crc_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be sent, and checksums that the engine still owes us.
  byte_req_t   byte_req_q[$];
  crc_t        crc_expect_q[$];
  byte_req_t   next_req;

  // Shadow copy of the configuration and of the running remainder.
  width_t      cur_width;
  crc_t        cur_poly;
  crc_t        cur_start;
  crc_t        cur_mask;
  logic        cur_refin;
  logic        cur_refout;
  crc_t        crc_shadow;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          src_gap        = 0;
  int          sink_stall     = 0;
  // When set, neither side inserts idle cycles (the last part of the run).
  bit          quiet          = 1'b0;

  // Bit-reverse the low w bits of v.
  function automatic crc_t mirror(input crc_t v, input int unsigned w);
    crc_t r;
    r = '0;
    for (int unsigned i = 0; i < w; i++) begin
      r = (r << 1) | crc_t'(v[0]);
      v = v >> 1;
    end
    return r;
  endfunction

  // Fold one accepted byte into the shadow remainder. A byte that closes a
  // message also produces the checksum the engine has to deliver.
  task automatic fold_request(input sym_t b, input logic first, input logic last);
    int unsigned w;
    crc_t        m;
    crc_t        poly;
    crc_t        rpoly;
    crc_t        r;
    // Out-of-range widths are clamped to the supported 8..16 bits.
    w = (cur_width < SymbolBits) ? SymbolBits :
        (cur_width > MaxCrcWidth) ? MaxCrcWidth : cur_width;
    m = crc_t'((17'h1 << w) - 17'h1);
    poly = cur_poly & m;
    r = crc_shadow & m;
    if (first) begin
      r = cur_start & m;
      if (cur_refin) begin
        r = mirror(r, w);
      end
    end
    if (cur_refin) begin
      // LSB-first update with the reflected generator.
      rpoly = mirror(poly, w);
      r = r ^ crc_t'(b);
      for (int i = 0; i < SymbolBits; i++) begin
        if (r[0]) begin
          r = (r >> 1) ^ rpoly;
        end else begin
          r = r >> 1;
        end
      end
    end else begin
      // MSB-first update; the byte lines up with the top of the register.
      r = r ^ (crc_t'(b) << (w - SymbolBits));
      for (int i = 0; i < SymbolBits; i++) begin
        if (r[w-1]) begin
          r = ((r << 1) ^ poly) & m;
        end else begin
          r = (r << 1) & m;
        end
      end
    end
    r = r & m;
    crc_shadow = r;
    if (last) begin
      if (cur_refin) begin
        r = mirror(r, w);
      end
      if (cur_refout) begin
        r = mirror(r, w);
      end
      crc_expect_q.push_back((r ^ cur_mask) & m);
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  // Driver: presents the queued requests, holding each one until it is taken.
  // Outside the quiet part, random idle cycles appear between requests.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap    <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (src_gap > 0) begin
        src_gap    <= src_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        src_gap    <= $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else if (byte_req_q.size() != 0) begin
        next_req     = byte_req_q.pop_front();
        in_valid_i   <= 1'b1;
        data_byte_i  <= next_req.data;
        first_byte_i <= next_req.first;
        last_byte_i  <= next_req.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: ready drops in random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_stall  <= 0;
    end else if (sink_stall > 0) begin
      sink_stall  <= sink_stall - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      sink_stall  <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: every accepted request goes through the predictor, and every
  // accepted checksum is compared against the oldest one still owed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        fold_request(data_byte_i, first_byte_i, last_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (crc_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected checksum %04h", crc_value_o));
        end else if (crc_value_o !== crc_expect_q[0]) begin
          note_mismatch($sformatf("checksum expected %04h, got %04h",
                                  crc_expect_q[0], crc_value_o));
          void'(crc_expect_q.pop_front());
        end else begin
          void'(crc_expect_q.pop_front());
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register write; the shadow copy follows it with the same masking the
  // engine applies. Only called while nothing is in flight.
  task automatic write_reg(input cfg_reg_e idx, input crc_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      REG_CRC_WIDTH:      cur_width  = width_t'(value);
      REG_POLYNOMIAL:     cur_poly   = value;
      REG_START_VALUE:    cur_start  = value;
      REG_OUTPUT_MASK:    cur_mask   = value;
      REG_REFLECT_INPUT:  cur_refin  = value[0];
      REG_REFLECT_OUTPUT: cur_refout = value[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_setup(input crc_t width, input crc_t poly, input crc_t start,
                             input crc_t mask, input logic refin, input logic refout);
    write_reg(REG_CRC_WIDTH, width);
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_START_VALUE, start);
    write_reg(REG_OUTPUT_MASK, mask);
    write_reg(REG_REFLECT_INPUT, crc_t'(refin));
    write_reg(REG_REFLECT_OUTPUT, crc_t'(refout));
  endtask

  task automatic queue_byte(input sym_t data, input logic first, input logic last);
    byte_req_t req;
    req.data  = data;
    req.first = first;
    req.last  = last;
    byte_req_q.push_back(req);
  endtask

  // Wait until every request is sent and every checksum has come back, then
  // give the engine a few more cycles for a trailing byte without a result.
  task automatic drain();
    while (byte_req_q.size() != 0 || in_valid_i || crc_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register values lean toward the all-zero and all-one corners.
  function automatic crc_t pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return crc_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic crc_t pick_width();
    case ($urandom_range(0, 5))
      0:       return crc_t'($urandom_range(0, 7));
      1:       return crc_t'($urandom_range(17, 31));
      default: return crc_t'($urandom_range(8, 16));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned len;

    // Shadow starts at the reset configuration (MODBUS) with a cleared remainder.
    cur_width  = RstCrcWidth;
    cur_poly   = RstPolynomial;
    cur_start  = RstStartValue;
    cur_mask   = RstOutputMask;
    cur_refin  = RstReflectIn;
    cur_refout = RstReflectOut;
    crc_shadow = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes with no message start continue from the cleared remainder.
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    // The classic check string "123456789" under the reset settings.
    for (int i = 0; i < 9; i++) begin
      queue_byte(sym_t'(8'h31 + i), i == 0, i == 8);
    end
    // One-byte messages, first and last on the same request.
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b1);
    drain();

    // Plain 8-bit CRC, MSB-first, no reflection on either side.
    write_setup(16'd8, 16'h0007, 16'h0000, 16'h0000, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h80, 1'b1, 1'b1);
    drain();

    // Width below range acts as 8; all-ones values are trimmed to the width.
    write_setup(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    queue_byte(8'hA5, 1'b1, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b1);
    drain();

    // Width above range acts as 16, reflected in but not out.
    write_setup(16'd31, 16'h1021, 16'h0000, 16'hA5A5, 1'b1, 1'b0);
    queue_byte(8'h01, 1'b1, 1'b0);
    queue_byte(8'hFE, 1'b0, 1'b1);
    drain();

    // A setting changed in the middle of a message: the remainder is kept
    // and the rest of the message uses the new polynomial.
    queue_byte(8'h12, 1'b1, 1'b0);
    drain();
    write_reg(REG_POLYNOMIAL, 16'h8BB7);
    queue_byte(8'h34, 1'b0, 1'b1);
    drain();

    // Random part: each phase draws a new setting, then mostly well-formed
    // messages with some stray bytes whose flags are random. A stray byte
    // can leave a message open across the next setting change.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if (ph >= RandPhases - QuietPhases) begin
        quiet = 1'b1;
      end
      write_setup(pick_width(), pick_value(), pick_value(), pick_value(),
                  logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
      sent = 0;
      while (sent < PhaseBytes) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_byte(sym_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)),
                     logic'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
          for (int unsigned i = 0; i < len; i++) begin
            queue_byte(sym_t'($urandom_range(0, 255)), i == 0, i == len - 1);
          end
          sent += len;
        end
      end
      drain();
    end

    if (mismatch_count == 0 && crc_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pcrc16_pkg.sv
src/parametric_crc16_engine_top.sv
dv/testbench.sv
